>>> hdl/bcea_pkg.sv
// Shared types, constants and log tables of the cross-entropy accumulator.
`default_nettype none

package bcea_pkg;

  localparam int LogTabN    = 256;
  localparam int IdxW       = $clog2(LogTabN + 1);
  localparam int PosW       = 15 + IdxW;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [63:0] Ln2Q30 = 64'd744261118;
  localparam logic [16:0] OneQ16 = 17'h10000;
  localparam logic [23:0] ScaleReset = 24'd65536;

  typedef logic [LogTabN:0][15:0] ln_tab_t;
  typedef logic [15:0][19:0]      base_tab_t;

  // One log term: weight and the operands of the interpolated -ln.
  typedef struct packed {
    logic [16:0] weight;
    logic        is_one;
    logic [15:0] a;
    logic [15:0] d;
    logic [14:0] rem;
    logic [19:0] base;
  } term_t;

  typedef struct packed {
    term_t [1:0] terms;
    logic        last;
  } entry_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [QCntW-1:0] count;
  } q_stat_t;

  // ln(1 + i/N) in Q0.16 from a 30-bit log2 by repeated squaring.
  function automatic logic [15:0] ln1p_entry(int unsigned i);
    logic [63:0] y;
    logic [63:0] l2;
    logic [63:0] prod;
    int          b;
    y  = (64'd1 << 30) + ((64'(i) << 30) / 64'(LogTabN));
    l2 = '0;
    if (y >= (64'd1 << 31)) begin
      l2 = 64'd1 << 30;
      y  = y >> 1;
    end
    for (b = 29; b >= 0; b--) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y  = y >> 1;
        l2 = l2 | (64'd1 << b);
      end
    end
    prod = l2 * Ln2Q30 + (64'd1 << 43);
    return 16'(prod >> 44);
  endfunction

  function automatic ln_tab_t build_ln_tab();
    ln_tab_t t;
    for (int i = 0; i <= LogTabN; i++) begin
      t[i] = ln1p_entry(i);
    end
    return t;
  endfunction

  // (s+1)*ln2 in Q4.16 for every normalize shift s.
  function automatic base_tab_t build_base_tab();
    base_tab_t t;
    for (int s = 0; s < 16; s++) begin
      t[s] = 20'(((64'(s + 1)) * Ln2Q30 + (64'd1 << 13)) >> 14);
    end
    return t;
  endfunction

  localparam ln_tab_t   LnTab   = build_ln_tab();
  localparam base_tab_t BaseTab = build_base_tab();

endpackage

`default_nettype wire

>>> hdl/bcea_front.sv
// Front end: saturates the probabilities and prepares both log terms of a word.
`default_nettype none

module bcea_front (
  input  logic [16:0]     predicted_i,
  input  logic [16:0]     target_i,
  input  logic            last_i,
  output bcea_pkg::entry_t entry_o
);
  import bcea_pkg::*;

  logic [16:0] p_sat;
  logic [16:0] t_sat;

  function automatic term_t make_term(logic [16:0] w, logic [16:0] arg);
    logic [15:0]     x;
    logic [15:0]     m;
    logic [3:0]      s;
    logic [14:0]     fr;
    logic [PosW-1:0] pos;
    logic [IdxW-1:0] idx;
    logic [IdxW-1:0] idx_n;
    logic [14:0]     rem;
    logic [15:0]     a;
    logic [15:0]     b;
    term_t           t;
    x = arg[15:0];
    if (x == 16'd0) begin
      x = 16'd1;
    end
    s = '0;
    for (int i = 0; i < 16; i++) begin
      if (x[i]) begin
        s = 4'(15 - i);
      end
    end
    m   = x << s;
    fr  = m[14:0];
    pos = PosW'(fr) * PosW'(LogTabN);
    idx = IdxW'(pos >> 15);
    rem = pos[14:0];
    if (idx >= IdxW'(LogTabN)) begin
      idx = IdxW'(LogTabN - 1);
      rem = '1;
    end
    idx_n    = idx + 1'b1;
    a        = LnTab[idx];
    b        = LnTab[idx_n];
    t.weight = w;
    t.is_one = arg[16];
    t.a      = a;
    t.d      = (b >= a) ? (b - a) : 16'd0;
    t.rem    = rem;
    t.base   = BaseTab[s];
    return t;
  endfunction

  assign p_sat = (predicted_i > OneQ16) ? OneQ16 : predicted_i;
  assign t_sat = (target_i > OneQ16) ? OneQ16 : target_i;

  // A zero weight yields a zero term, so both terms always run.
  always_comb begin
    entry_o.terms[0] = make_term(t_sat, p_sat);
    entry_o.terms[1] = make_term(OneQ16 - t_sat, OneQ16 - p_sat);
    entry_o.last     = last_i;
  end

endmodule

`default_nettype wire

>>> hdl/bcea_queue.sv
// Short queue of prepared words between the front end and the back end.
`default_nettype none

module bcea_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bcea_pkg::entry_t  entry_i,
  input  logic              pop_i,
  output bcea_pkg::entry_t  head_o,
  output bcea_pkg::q_stat_t stat_o
);
  import bcea_pkg::*;

  entry_t           mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;

  function automatic logic [QPtrW-1:0] next_ptr(logic [QPtrW-1:0] p);
    return (p == QPtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == QCntW'(QueueDepth));
  assign stat_o.empty = (count_q == '0);
  assign stat_o.count = count_q;

endmodule

`default_nettype wire

>>> hdl/bcea_back.sv
// Back end: interpolates -ln, weights and accumulates the terms, scales the sum.
`default_nettype none

module bcea_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic signed [23:0]  scale_i,
  input  bcea_pkg::entry_t    head_i,
  input  bcea_pkg::q_stat_t   stat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [39:0]         loss_o
);
  import bcea_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LERP  = 6'b000010,
    S_PROD  = 6'b000100,
    S_ACC   = 6'b001000,
    S_SCALE = 6'b010000,
    S_EMIT  = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  logic               sel_q, sel_d;
  logic [16:0]        lnf_q, lnf_d;
  logic [20:0]        term_q, term_d;
  logic [31:0]        sum_q, sum_d;
  logic signed [56:0] prod_q, prod_d;
  logic [39:0]        loss_q, loss_d;
  logic               out_valid_q, out_valid_d;

  term_t              cur;
  logic [30:0]        lerp;
  logic [19:0]        neg;
  logic [36:0]        mult;
  logic [32:0]        acc;
  logic signed [56:0] sum_ext;
  logic signed [56:0] scale_ext;
  logic signed [56:0] rnd;
  logic               can_load;

  assign cur       = head_i.terms[sel_q];
  assign lerp      = 31'(cur.d) * 31'(cur.rem) + 31'd16384;
  assign neg       = (cur.is_one || (cur.base <= 20'(lnf_q))) ? 20'd0
                                                              : cur.base - 20'(lnf_q);
  assign mult      = 37'(cur.weight) * 37'(neg) + 37'd32768;
  assign acc       = {1'b0, sum_q} + 33'(term_q);
  assign sum_ext   = 57'(signed'({1'b0, sum_q}));
  assign scale_ext = 57'(scale_i);
  assign rnd       = prod_q + 57'sd32768;
  assign can_load  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    lnf_d       = lnf_q;
    term_d      = term_q;
    sum_d       = sum_q;
    prod_d      = prod_q;
    loss_d      = loss_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pop_o       = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!stat_i.empty) begin
          sel_d   = 1'b0;
          state_d = S_LERP;
        end
      end
      S_LERP: begin
        lnf_d   = 17'(cur.a) + 17'(lerp >> 15);
        state_d = S_PROD;
      end
      S_PROD: begin
        term_d  = 21'(mult >> 16);
        state_d = S_ACC;
      end
      S_ACC: begin
        sum_d = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
        if (!sel_q) begin
          sel_d   = 1'b1;
          state_d = S_LERP;
        end else if (head_i.last) begin
          state_d = S_SCALE;
        end else begin
          pop_o   = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SCALE: begin
        prod_d  = sum_ext * scale_ext;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        // The product stays below 2^55 in magnitude, so the result never clips.
        if (can_load) begin
          loss_d      = rnd[55:16];
          out_valid_d = 1'b1;
          sum_d       = '0;
          pop_o       = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= 1'b0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lnf_q  <= lnf_d;
    term_q <= term_d;
    prod_q <= prod_d;
    loss_q <= loss_d;
  end

  assign out_valid_o = out_valid_q;
  assign loss_o      = loss_q;

endmodule

`default_nettype wire

>>> hdl/binary_cross_entropy_accumulator_top.sv
// Top level of the binary cross-entropy accumulator.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata: predicted [16:0], target [33:17]; tlast: last_feature_map
//   m_axis    out        tdata: loss [39:0], signed Q24.16
//   cfg       in         cfg_wdata_i: loss_scale, signed Q8.16
//
// A word enters the two-deep queue in the cycle it is accepted. The back end
// handles a word in a load state and then, for each of the two log terms, the
// interpolate, multiply and accumulate states of the shared interpolate and
// multiply unit; a word with tlast set adds the scale multiply and the output load.
// Reset clears the sum and sets loss_scale to 1.0. A stalled m_axis only holds
// the back end on a tlast word; s_axis_tready drops when the queue is full.
`default_nettype none

module binary_cross_entropy_accumulator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // predicted, target, zero padding
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // loss
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i
);
  import bcea_pkg::*;

  logic [23:0] scale_q;
  entry_t      front_entry;
  entry_t      head;
  q_stat_t     q_stat;
  logic        q_push;
  logic        q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleReset;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready = !q_stat.full;
  assign q_push        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tlast  = 1'b1;

  bcea_front u_front (
    .predicted_i (s_axis_tdata[16:0]),
    .target_i    (s_axis_tdata[33:17]),
    .last_i      (s_axis_tlast),
    .entry_o     (front_entry)
  );

  bcea_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (front_entry),
    .pop_i   (q_pop),
    .head_o  (head),
    .stat_o  (q_stat)
  );

  bcea_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scale_i     (signed'(scale_q)),
    .head_i      (head),
    .stat_i      (q_stat),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .loss_o      (m_axis_tdata)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("queue read while empty");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(rst_ni) && $past(q_push) && !$past(q_pop))
      |-> (q_stat.count == QCntW'($past(q_stat.count) + 1'b1)))
    else $error("queue count lost a word");

endmodule

`default_nettype wire
